FILE: rtl/anv_pkg.sv
// ---------------------------------------------------------------------------
// anv_pkg
// Shared types, constants and character-class helpers for the account name
// validator.
// ---------------------------------------------------------------------------
package anv_pkg;

    // Register indexes on the configuration port
    localparam logic CFG_MIN_LENGTH = 1'b0;
    localparam logic CFG_MAX_LENGTH = 1'b1;

    // Register reset values
    localparam logic [7:0] MIN_LENGTH_RESET = 8'd3;
    localparam logic [7:0] MAX_LENGTH_RESET = 8'd16;

    // Characters with special meaning
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_HYPHEN = 8'h2D;

    // Segment length floor and total count ceiling
    localparam logic [1:0] SEG_MIN   = 2'd3;
    localparam logic [8:0] TOTAL_MAX = 9'd511;

    typedef enum logic [1:0] {
        VERDICT_VALID     = 2'd0,
        VERDICT_TOO_SHORT = 2'd1,
        VERDICT_TOO_LONG  = 2'd2,
        VERDICT_BAD_SEQ   = 2'd3
    } verdict_t;

    // One name byte moving into the checker
    typedef struct packed {
        logic       valid;
        logic [7:0] char_byte;
        logic       is_final;
    } char_step_t;

    // Checker status back to the top level
    typedef struct packed {
        logic name_idle;   // no bytes of a name collected
    } name_status_t;

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

FILE: rtl/anv_name_check.sv
// ---------------------------------------------------------------------------
// anv_name_check
// Per-name running state (counts and flags) and the verdict for the final
// byte of a name.
// ---------------------------------------------------------------------------
module anv_name_check
    import anv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  char_step_t   step,
    input  logic [7:0]   min_length,
    input  logic [7:0]   max_length,
    output verdict_t     verdict,
    output name_status_t status
);

    logic [8:0] total_reg, total_next;
    logic [1:0] seg_reg, seg_next;
    logic       hyph_reg, hyph_next;
    logic       bad_reg, bad_next;

    logic [8:0] total_upd;
    logic [1:0] seg_upd;
    logic       hyph_upd;
    logic       bad_upd;
    logic       bad_final;
    logic [7:0] c;

    assign c = step.char_byte;

    // Byte step: class check and counter update
    always_comb
    begin
        total_upd = (total_reg < TOTAL_MAX) ? total_reg + 9'd1 : total_reg;
        seg_upd   = seg_reg;
        hyph_upd  = hyph_reg;
        bad_upd   = bad_reg;
        if (c == CHAR_DOT)
        begin
            if ((seg_reg < SEG_MIN) || hyph_reg)
                bad_upd = 1'b1;
            seg_upd  = 2'd0;
            hyph_upd = 1'b0;
        end
        else
        begin
            if (seg_reg == 2'd0)
            begin
                if (!is_lower(c))
                    bad_upd = 1'b1;
            end
            else if (!(is_lower(c) || is_digit(c) || (c == CHAR_HYPHEN)))
            begin
                bad_upd = 1'b1;
            end
            hyph_upd = (c == CHAR_HYPHEN);
            if (seg_reg < SEG_MIN)
                seg_upd = seg_reg + 2'd1;
        end
    end

    // Verdict: length checks first, then the segment rules
    assign bad_final = bad_upd || (seg_upd < SEG_MIN) || hyph_upd;

    always_comb
    begin
        priority if (total_upd < {1'b0, min_length})
            verdict = VERDICT_TOO_SHORT;
        else if (total_upd > {1'b0, max_length})
            verdict = VERDICT_TOO_LONG;
        else if (bad_final)
            verdict = VERDICT_BAD_SEQ;
        else
            verdict = VERDICT_VALID;
    end

    // Next state: clear after the final byte
    always_comb
    begin
        total_next = total_reg;
        seg_next   = seg_reg;
        hyph_next  = hyph_reg;
        bad_next   = bad_reg;
        if (step.valid)
        begin
            if (step.is_final)
            begin
                total_next = '0;
                seg_next   = '0;
                hyph_next  = 1'b0;
                bad_next   = 1'b0;
            end
            else
            begin
                total_next = total_upd;
                seg_next   = seg_upd;
                hyph_next  = hyph_upd;
                bad_next   = bad_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            seg_reg   <= '0;
            hyph_reg  <= 1'b0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            total_reg <= total_next;
            seg_reg   <= seg_next;
            hyph_reg  <= hyph_next;
            bad_reg   <= bad_next;
        end
    end

    assign status.name_idle = (total_reg == 9'd0);

endmodule

FILE: rtl/account_name_validator_top.sv
// ---------------------------------------------------------------------------
// account_name_validator_top
// Streams a name in one byte per word and returns one verdict word per name.
// ---------------------------------------------------------------------------
// Takes one name byte per clock cycle, back to back except while a final byte
// waits, and gives one verdict (valid, too short, too long, invalid sequence)
// per name. Each byte is taken into the input register, where the class check
// and counter update run, and the verdict of a final byte is then registered
// in the output register. Bytes without the final flag never wait on the
// output side. A final byte waits only while an earlier verdict is still held
// there by out_stall. The user must write min_length and max_length through
// the configuration port only while no name is in flight; the block itself
// does not enforce this.
module account_name_validator_top
    import anv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // Input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_byte,
    input  logic       is_final,
    // Output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] verdict,
    // Configuration port
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_char_reg;
    logic       s1_final_reg;
    logic       out_valid_reg, out_valid_next;
    verdict_t   verdict_reg;
    logic [7:0] min_length_reg;
    logic [7:0] max_length_reg;

    logic         in_accept;
    logic         out_accept;
    logic         out_free;
    logic         s1_advance;
    char_step_t   step;
    verdict_t     verdict_calc;
    name_status_t status;

    // Handshake
    assign out_accept = out_valid_reg && !out_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && (!s1_final_reg || out_free);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= MIN_LENGTH_RESET;
            max_length_reg <= MAX_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_LENGTH: min_length_reg <= cfg_data;
                CFG_MAX_LENGTH: max_length_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Input register
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_char_reg  <= char_byte;
            s1_final_reg <= is_final;
        end
    end

    // Name checker
    assign step.valid     = s1_advance;
    assign step.char_byte = s1_char_reg;
    assign step.is_final  = s1_final_reg;

    anv_name_check u_name_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .min_length (min_length_reg),
        .max_length (max_length_reg),
        .verdict    (verdict_calc),
        .status     (status)
    );

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_advance && s1_final_reg)
            out_valid_next = 1'b1;
        else if (out_accept)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_final_reg)
            verdict_reg <= verdict_calc;
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    // Checks
    a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_final_reg))
        else $error("verdict appeared without a final byte");

    a_clear_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_final_reg) |=> status.name_idle)
        else $error("name state not cleared after verdict");

    a_stall_only_final: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s1_final_reg && out_valid_reg))
        else $error("input stalled without a pending verdict");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(verdict_reg))
        else $error("held verdict overwritten");

endmodule

FILE: tb/sv/tb_account_name_validator_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_account_name_validator_top
// Self-checking testbench for the account name validator. Names are streamed
// in one byte per word, each verdict is predicted in the bench from the
// segment and length rules, and every returned verdict word is compared with
// the oldest prediction. Directed names and length limits come first, then
// random phases with different length settings, with random idling on both
// channels in all but one phase.
// ---------------------------------------------------------------------------
module tb_account_name_validator_top;
    import anv_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] char_byte;
    logic       is_final;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] verdict;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_data;

    account_name_validator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_byte (char_byte),
        .is_final  (is_final),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .verdict   (verdict),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted state of the name checker
    logic [7:0] min_len;
    logic [7:0] max_len;
    logic [8:0] name_len;
    logic [1:0] seg_len;
    logic       hyphen_seen;
    logic       seq_broken;

    verdict_t   verdict_q[$];
    logic [7:0] name_buf[$];
    int         fail_cnt;
    int         bytes_sent;
    bit         in_gap_en;
    bit         out_stall_en;
    verdict_t   exp_verdict;

    // Append one expected verdict
    function automatic void queue_verdict(verdict_t v);
        verdict_q.insert(verdict_q.size(), v);
    endfunction

    // Append one byte to the name being built
    function automatic void append_byte(logic [7:0] b);
        name_buf.insert(name_buf.size(), b);
    endfunction

    // -----------------------------------------------------------------------
    // Clock and output-side stall
    // -----------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Idle lengths: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    initial
    begin
        int hold;
        hold = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (out_stall_en && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                hold = pick_gap();
            end
            else
                out_stall <= 1'b0;
        end
    end

    // -----------------------------------------------------------------------
    // Verdict predictor: one accepted byte
    // -----------------------------------------------------------------------
    function automatic bit is_lc(logic [7:0] c);
        return c >= "a" && c <= "z";
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void predict_char(logic [7:0] c, logic fin);
        if (name_len < TOTAL_MAX)
            name_len++;
        if (c == CHAR_DOT)
        begin
            if (seg_len < SEG_MIN || hyphen_seen)
                seq_broken = 1'b1;
            seg_len     = '0;
            hyphen_seen = 1'b0;
        end
        else
        begin
            if (seg_len == 0)
            begin
                if (!is_lc(c))
                    seq_broken = 1'b1;
            end
            else if (!(is_lc(c) || is_num(c) || c == CHAR_HYPHEN))
                seq_broken = 1'b1;
            hyphen_seen = (c == CHAR_HYPHEN);
            if (seg_len < SEG_MIN)
                seg_len++;
        end
        if (fin)
        begin
            if (seg_len < SEG_MIN || hyphen_seen)
                seq_broken = 1'b1;
            // length checks take priority over the segment rules
            if (name_len < {1'b0, min_len})
                queue_verdict(VERDICT_TOO_SHORT);
            else if (name_len > {1'b0, max_len})
                queue_verdict(VERDICT_TOO_LONG);
            else if (seq_broken)
                queue_verdict(VERDICT_BAD_SEQ);
            else
                queue_verdict(VERDICT_VALID);
            name_len    = '0;
            seg_len     = '0;
            hyphen_seen = 1'b0;
            seq_broken  = 1'b0;
        end
    endfunction

    // -----------------------------------------------------------------------
    // Verdict checker
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t: unexpected verdict word %0d", $time, verdict);
                fail_cnt++;
            end
            else
            begin
                exp_verdict = verdict_q.pop_front();
                if (verdict !== exp_verdict)
                begin
                    $display("%0t: verdict mismatch, expected %0d (%s), actual %0d",
                             $time, exp_verdict, exp_verdict.name(), verdict);
                    fail_cnt++;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Input side; every task starts and ends at a falling edge
    // -----------------------------------------------------------------------
    task automatic send_char(logic [7:0] c, logic fin);
        int gap;
        gap = in_gap_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        char_byte <= c;
        is_final  <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_char(c, fin);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_name();
        foreach (name_buf[i])
            send_char(name_buf[i], i == name_buf.size() - 1);
    endtask

    task automatic send_text(string s);
        name_buf.delete();
        for (int i = 0; i < s.len(); i++)
            append_byte(s[i]);
        send_name();
    endtask

    // Drop valid and wait until every verdict is back and the pipe is empty
    task automatic drain();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_MIN_LENGTH)
            min_len = val;
        else
            max_len = val;
    endtask

    task automatic set_lengths(logic [7:0] lo, logic [7:0] hi);
        drain();
        write_reg(CFG_MIN_LENGTH, lo);
        write_reg(CFG_MAX_LENGTH, hi);
    endtask

    // -----------------------------------------------------------------------
    // Name builders (fill name_buf)
    // -----------------------------------------------------------------------
    function automatic logic [7:0] rand_inner();
        case ($urandom_range(0, 5))
            0:       return 8'($urandom_range("0", "9"));
            1:       return CHAR_HYPHEN;
            default: return 8'($urandom_range("a", "z"));
        endcase
    endfunction

    function automatic void add_segment(int n);
        append_byte(8'($urandom_range("a", "z")));
        for (int i = 1; i < n - 1; i++)
            append_byte(rand_inner());
        if (n > 1)
            append_byte(8'(($urandom_range(0, 3) == 0) ?
                           $urandom_range("0", "9") : $urandom_range("a", "z")));
    endfunction

    // Well-formed name of exactly len bytes (len >= 3)
    function automatic void build_valid_name(int len);
        int left;
        int seg;
        name_buf.delete();
        left = len;
        while (left > 0)
        begin
            if (left <= 10)
                seg = left;
            else
                seg = $urandom_range(3, (left - 4 < 10) ? left - 4 : 10);
            add_segment(seg);
            left -= seg;
            if (left > 0)
            begin
                append_byte(CHAR_DOT);
                left--;
            end
        end
    endfunction

    function automatic void build_random_name();
        int len;
        int pos;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 60) : $urandom_range(3, 24);
        build_valid_name(len);
        pos = $urandom_range(0, name_buf.size() - 1);
        case ($urandom_range(0, 9))
            6:  name_buf[pos] = 8'($urandom_range(0, 255));
            7:  name_buf[pos] = 8'($urandom_range("A", "Z"));
            8:  name_buf[pos] = ($urandom_range(0, 1) == 1) ? CHAR_DOT : CHAR_HYPHEN;
            9:
            begin
                // byte noise, leaning on the special characters
                name_buf.delete();
                len = $urandom_range(1, 12);
                repeat (len)
                begin
                    case ($urandom_range(0, 4))
                        0:       append_byte(CHAR_DOT);
                        1:       append_byte(CHAR_HYPHEN);
                        default: append_byte(8'($urandom_range(0, 255)));
                    endcase
                end
            end
            default: ;
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------
    // Segment rules at the reset lengths (3..16)
    task automatic test_segment_rules();
        send_text("abc");
        send_text("ab");
        send_text("a0-b.c-9.xyz");
        send_text("Abc");
        send_text("1bc");
        send_text("ab-");
        send_text(".abc");
        send_text("abc.");
        send_text("abc..def");
        send_text("ab-.cde");
        send_text("ab.cde");
        send_text("a_c");
        send_text("abcdefghijklmnop");
        send_text("abcdefghijklmnopq");
        name_buf.delete();
        append_byte("a");
        append_byte(8'hFF);
        append_byte(8'h00);
        send_name();
    endtask

    // Total length saturates and still reads as too long
    task automatic test_length_saturation();
        set_lengths(8'd3, 8'd255);
        build_valid_name(512);
        send_name();
    endtask

    // Register extremes, including min above max
    task automatic test_length_limits();
        set_lengths(8'd3, 8'd3);
        send_text("abc");
        send_text("abcd");
        send_text("ab");
        set_lengths(8'd255, 8'd255);
        send_text("abc");
        set_lengths(8'd10, 8'd5);
        send_text("abcd");
        send_text("abcdefg");
        send_text("abcdefghijkl");
    endtask

    // Random names over several length settings and idling patterns
    task automatic test_random_names();
        int lo;
        int hi;
        int stop_at;
        for (int ph = 0; ph < 3; ph++)
        begin
            lo = $urandom_range(3, 12);
            hi = (ph == 2) ? $urandom_range(3, lo) : $urandom_range(lo, 30);
            set_lengths(lo[7:0], hi[7:0]);
            in_gap_en    = (ph != 1);
            out_stall_en = (ph != 1);
            stop_at = bytes_sent + 20;
            while (bytes_sent < stop_at)
            begin
                build_random_name();
                send_name();
            end
        end
        in_gap_en    = 1'b1;
        out_stall_en = 1'b1;
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        char_byte    = '0;
        is_final     = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_MIN_LENGTH;
        cfg_data     = '0;
        min_len      = MIN_LENGTH_RESET;
        max_len      = MAX_LENGTH_RESET;
        name_len     = '0;
        seg_len      = '0;
        hyphen_seen  = 1'b0;
        seq_broken   = 1'b0;
        fail_cnt     = 0;
        bytes_sent   = 0;
        in_gap_en    = 1'b1;
        out_stall_en = 1'b1;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_segment_rules();
        test_length_saturation();
        test_length_limits();
        test_random_names();

        // wait out the remaining verdicts, bounded
        in_valid <= 1'b0;
        for (int i = 0; i < 5000 && verdict_q.size() != 0; i++)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (verdict_q.size() != 0)
        begin
            $display("%0t: %0d verdicts never arrived, next expected %0d",
                     $time, verdict_q.size(), verdict_q[0]);
            fail_cnt++;
        end
        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(15_000_000);
        $display("%0t: timeout", $time);
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/anv_pkg.sv
rtl/anv_name_check.sv
rtl/account_name_validator_top.sv
tb/sv/tb_account_name_validator_top.sv
